/* rtl/core/sdd_pkg.sv */
package sdd_pkg;

  // default deck length and fixed field widths
  localparam int DECK_SIZE_DEF = 64;
  localparam int CARD_W        = 6;
  localparam int SEED_W        = 32;
  localparam int OUT_TDATA_W   = 8;

  // xorshift32 shift amounts
  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

  // operation codes carried on the input tuser
  localparam logic OP_SHUFFLE = 1'b0;
  localparam logic OP_DRAW    = 1'b1;

  // status of the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

  // one step of the xorshift32 generator
  function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] x;
    x = s;
    x = x ^ (x << XS_A);
    x = x ^ (x >> XS_B);
    x = x ^ (x << XS_C);
    return x;
  endfunction

endpackage

/* rtl/core/shuffled_deck_dealer.sv */
// shuffled deck dealer
// Keeps a permutation of 0..DECK_SIZE-1 and a draw position.
// Input channel (in_*): in_tuser[0] is the opcode (shuffle or draw), in_tdata
// is the 32-bit seed of a shuffle (zero is taken as one; ignored on a draw).
// Output channel (out_*): one transaction per input transaction; out_tdata
// carries the drawn card, out_tuser[0] is set on the result of a shuffle.
// A draw reads its card through the registered RAM read port into the output register.
// A shuffle first writes the identity order, then does one
// Fisher-Yates swap per entry from the top down; each swap steps through
// the bit-serial remainder unit (for j = rand mod (i+1)) and then the
// read/read/write/write sequence on the deck RAM (one write, one read port).
// One item is worked on at a time; in_tready is low meanwhile.
// Reset clears the draw position and the control state; deck contents are
// undefined until the first shuffle. When the receiver stalls, the result
// waits in the output register and the block finishes the next item up to
// its result, then holds there.
module shuffled_deck_dealer #(
  parameter int DECK_SIZE = sdd_pkg::DECK_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sdd_pkg::SEED_W-1:0]     in_tdata,   // [31:0] seed
  input  logic [0:0]                     in_tuser,   // [0] opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sdd_pkg::OUT_TDATA_W-1:0] out_tdata, // [5:0] card, [7:6] zero
  output logic [0:0]                     out_tuser   // [0] shuffle_done
);

  localparam int IW = $clog2(DECK_SIZE);
  localparam int DW = $clog2(DECK_SIZE + 1);
  localparam int CW = sdd_pkg::CARD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_GEN, S_MOD, S_RD_I, S_RD_J, S_WR_I, S_WR_J, S_DRAW, S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [sdd_pkg::SEED_W-1:0] st_r, st_nxt;
  logic [IW-1:0]              pos_r, pos_nxt;
  logic [IW-1:0]              cnt_r, cnt_nxt;
  logic [IW-1:0]              i_r, i_nxt;
  logic [IW-1:0]              j_r, j_nxt;
  logic [IW-1:0]              tmp_r, tmp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [CW-1:0]              card_r, card_nxt;
  logic                       done_r, done_nxt;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [IW-1:0]              ram_wdata;
  logic [IW-1:0]              ram_raddr;
  logic [IW-1:0]              ram_rdata;
  logic [CW+IW-1:0]           card_ext;

  logic                       mod_start;
  logic [sdd_pkg::SEED_W-1:0] mod_dividend;
  logic [DW-1:0]              mod_divisor;
  logic [DW-1:0]              mod_rem;
  sdd_pkg::mod_status_t       mod_stat;

  logic                       in_acc;
  logic                       out_free;

  sdd_ram #(
    .WIDTH (IW),
    .DEPTH (DECK_SIZE)
  ) u_deck (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sdd_modu #(
    .DW (DW)
  ) u_modu (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .remainder (mod_rem),
    .status    (mod_stat)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign card_ext  = {{CW{1'b0}}, ram_rdata};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r;
    card_nxt      = card_r;
    done_nxt      = done_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = cnt_r;
    ram_raddr     = pos_r;
    mod_start     = 1'b0;
    mod_dividend  = sdd_pkg::xorshift32(st_r);
    mod_divisor   = DW'(i_r) + DW'(1);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == sdd_pkg::OP_SHUFFLE) begin
            st_nxt    = (in_tdata != '0) ? in_tdata : sdd_pkg::SEED_W'(1);
            cnt_nxt   = '0;
            state_nxt = S_FILL;
          end else begin
            state_nxt = S_DRAW;
          end
        end
      end
      S_FILL: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + IW'(1);
        if (cnt_r == IW'(DECK_SIZE - 1)) begin
          i_nxt     = IW'(DECK_SIZE - 1);
          state_nxt = S_GEN;
        end
      end
      S_GEN: begin
        st_nxt    = mod_dividend;
        mod_start = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (mod_stat.done) begin
          j_nxt     = IW'(mod_rem);
          state_nxt = S_RD_I;
        end
      end
      S_RD_I: begin
        ram_raddr = i_r;
        state_nxt = S_RD_J;
      end
      S_RD_J: begin
        ram_raddr = j_r;
        tmp_nxt   = ram_rdata;
        state_nxt = S_WR_I;
      end
      S_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
        state_nxt = S_WR_J;
      end
      S_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = tmp_r;
        if (i_r == IW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r - IW'(1);
          state_nxt = S_GEN;
        end
      end
      S_DRAW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          card_nxt      = card_ext[CW-1:0];
          done_nxt      = 1'b0;
          pos_nxt       = (pos_r == IW'(DECK_SIZE - 1)) ? '0 : pos_r + IW'(1);
          state_nxt     = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          card_nxt      = '0;
          done_nxt      = 1'b1;
          pos_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    st_r   <= st_nxt;
    cnt_r  <= cnt_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    tmp_r  <= tmp_nxt;
    card_r <= card_nxt;
    done_r <= done_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = sdd_pkg::OUT_TDATA_W'(card_r);
  assign out_tuser[0] = done_r;

endmodule

/* rtl/core/sdd_ram.sv */
module sdd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/sdd_modu.sv */
module sdd_modu #(
  parameter int DW = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sdd_pkg::SEED_W-1:0] dividend,
  input  logic [DW-1:0]             divisor,
  output logic [DW-1:0]             remainder,
  output sdd_pkg::mod_status_t      status
);

  localparam int CW = $clog2(sdd_pkg::SEED_W);

  logic [sdd_pkg::SEED_W-1:0] x_r, x_nxt;
  logic [DW-1:0]              d_r;
  logic [DW-1:0]              r_r, r_nxt;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [DW:0]                shifted;

  // restoring remainder, one dividend bit per cycle while busy
  always_comb begin
    shifted = {r_r, x_r[sdd_pkg::SEED_W-1]};
    if (shifted >= {1'b0, d_r}) begin
      r_nxt = DW'(shifted - {1'b0, d_r});
    end else begin
      r_nxt = DW'(shifted);
    end
    x_nxt = {x_r[sdd_pkg::SEED_W-2:0], 1'b0};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(sdd_pkg::SEED_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
      d_r <= divisor;
      r_r <= '0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      r_r <= r_nxt;
    end
  end

  assign remainder   = r_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

/* rtl/core/sdd_checker.sv */
module sdd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sdd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // a shuffle acknowledge carries no card
  a_shuffle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("shuffle result with nonzero card");

  // padding bits above the card stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[sdd_pkg::OUT_TDATA_W-1:sdd_pkg::CARD_W] == '0)
    else $error("padding bits set");

  // a draw never comes back in the cycle right after its acceptance
  a_draw_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == sdd_pkg::OP_DRAW && !out_tvalid
      |=> !out_tvalid)
    else $error("draw result too early");

endmodule

bind shuffled_deck_dealer sdd_checker u_sdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DECK       = sdd_pkg::DECK_SIZE_DEF;
  localparam int N_ITEMS    = 1350;
  localparam int LONG_HOLD  = 400;
  localparam int TAIL_WAIT  = 20;
  localparam int CYCLE_MAX  = 1_000_000;

  // one expected result transaction
  typedef struct {
    logic [sdd_pkg::CARD_W-1:0] card;
    logic                       done;
  } deal_t;

  // predicts dealt cards and checks the result stream in order
  class deck_scoreboard;
    logic [15:0] deck [DECK];
    int unsigned pos;
    deal_t       pending_deals[$];
    int          n_errors;

    function new();
      pos      = 0;
      n_errors = 0;
    endfunction

    function logic [31:0] xs_step(logic [31:0] s);
      logic [31:0] x;
      x = s;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
    endfunction

    // work out the result of one accepted input transaction
    function void note_input(logic op, logic [31:0] seed);
      logic [31:0] st;
      logic [31:0] j;
      logic [15:0] t;
      deal_t       e;
      if (op == sdd_pkg::OP_SHUFFLE) begin
        st = (seed == 32'd0) ? 32'd1 : seed;
        for (int unsigned i = 0; i < DECK; i++) deck[i] = 16'(i);
        // fisher-yates pass from the top entry down to entry 1
        for (int unsigned i = DECK - 1; i > 0; i--) begin
          st = xs_step(st);
          j = st % 32'(i + 1);
          t = deck[i];
          deck[i] = deck[j];
          deck[j] = t;
        end
        pos    = 0;
        e.card = '0;
        e.done = 1'b1;
      end else begin
        e.card = deck[pos][sdd_pkg::CARD_W-1:0];
        e.done = 1'b0;
        pos    = (pos + 1) % DECK;
      end
      pending_deals.push_back(e);
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(logic [sdd_pkg::OUT_TDATA_W-1:0] data, logic [0:0] user);
      deal_t                           e;
      logic [sdd_pkg::OUT_TDATA_W-1:0] want_data;
      if (pending_deals.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, data, user);
      end else begin
        e = pending_deals.pop_front();
        want_data = sdd_pkg::OUT_TDATA_W'(e.card);
        if (data !== want_data) begin
          n_errors++;
          $display("%0t: card mismatch expected %h actual %h", $time, want_data, data);
        end
        if (user[0] !== e.done) begin
          n_errors++;
          $display("%0t: shuffle_done mismatch expected %b actual %b",
                   $time, e.done, user[0]);
        end
      end
    endfunction

    function int pending();
      return pending_deals.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [sdd_pkg::SEED_W-1:0]      in_tdata;
  logic [0:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [sdd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]                      out_tuser;

  deck_scoreboard sb = new();
  bit             idle_on;
  bit             hold_req;
  int             n_sent;
  int unsigned    cycles = 0;

  shuffled_deck_dealer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("%0t: timeout", $time);
      $display("** shuffled_deck_dealer: FAILED **");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // result receiver with random stalls and one long hold-off on request
  initial begin
    int stall;
    bit hold_seen;
    out_tready = 1'b0;
    hold_seen  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (idle_on) begin
        stall = $urandom_range(0, 8);
        if (stall > 0) begin
          out_tready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // offer one input transaction; entered and left at a falling edge
  task automatic send_item(logic op, logic [31:0] seed);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = $urandom;
      in_tuser  = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = seed;
    in_tuser  = op;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, seed);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_draws(int n);
    repeat (n) send_item(sdd_pkg::OP_DRAW, $urandom);
  endtask

  // hold the sender until every expected result has come back
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_seed();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return 32'd1;
    return $urandom;
  endfunction

  // stimulus
  initial begin
    int run_idx;
    int r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = sdd_pkg::OP_SHUFFLE;
    idle_on   = 1'b0;
    hold_req  = 1'b0;
    n_sent    = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: zero seed, all-ones seed, seed one (same deck as zero), top bit only
    send_item(sdd_pkg::OP_SHUFFLE, 32'd0);
    send_draws(4);
    send_item(sdd_pkg::OP_SHUFFLE, 32'hFFFF_FFFF);
    send_draws(4);
    send_item(sdd_pkg::OP_SHUFFLE, 32'd1);
    send_draws(4);
    send_item(sdd_pkg::OP_SHUFFLE, 32'h8000_0000);
    send_item(sdd_pkg::OP_DRAW, 32'hFFFF_FFFF);
    send_item(sdd_pkg::OP_DRAW, 32'd0);
    send_item(sdd_pkg::OP_DRAW, 32'h5A5A_A5A5);

    // random runs: mostly a shuffle followed by a run of draws
    run_idx = 0;
    while (n_sent < N_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (run_idx == 3) begin
        // long receiver hold-off while draws keep coming
        hold_req = ~hold_req;
        send_draws(30);
      end else if (run_idx == 6) begin
        wait_drained();
        send_draws(5);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          send_item(sdd_pkg::OP_SHUFFLE, pick_seed());
          send_draws($urandom_range(1, 150));
        end else if (r < 90) begin
          send_draws($urandom_range(1, 20));
        end else begin
          // back-to-back shuffles with few draws between
          send_item(sdd_pkg::OP_SHUFFLE, pick_seed());
          send_draws($urandom_range(0, 3));
          send_item(sdd_pkg::OP_SHUFFLE, pick_seed());
        end
      end
      run_idx++;
    end

    // drain and let the block settle
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("** shuffled_deck_dealer: PASSED **");
    end else begin
      $display("** shuffled_deck_dealer: FAILED **");
    end
    $finish;
  end

endmodule
